FILE: rtl/lmts_pkg.sv
package lmts_pkg;

  // line timing, in dots
  localparam int unsigned DotsPerLine = 456;
  localparam logic [9:0] DOTS_PER_LINE = 10'(DotsPerLine);
  localparam logic [9:0] OAM_END_DOT   = 10'd80;
  localparam logic [9:0] DRAW_END_DOT  = 10'd252;
  localparam logic [9:0] DOT_MAX       = 10'h3FF;

  // frame timing, in lines
  localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE         = 8'd153;

  // status interrupt source enable bits
  localparam int unsigned IRQ_HBLANK    = 0;
  localparam int unsigned IRQ_VBL_ENTRY = 1;
  localparam int unsigned IRQ_OAM       = 2;
  localparam int unsigned IRQ_COINC     = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [9:0] dot_count;
    logic [7:0] cur_line;
    mode_e      cur_mode;
    logic       coinc_flag;
  } lmts_state_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] line;
    logic       coincidence;
    logic       status_irq;
    logic       vblank_irq;
    logic       frame_done;
    logic       render_line;
  } lmts_result_t;

endpackage

FILE: rtl/lmts_if.sv
// input beat channel
interface lmts_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] dots;
  logic       lcd_enable;
  logic [7:0] compare_line;
  logic [3:0] irq_enables;

  modport source (output valid, dots, lcd_enable, compare_line, irq_enables, input ready);
  modport sink   (input valid, dots, lcd_enable, compare_line, irq_enables, output ready);
endinterface

// result beat channel
interface lmts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] line;
  logic       coincidence;
  logic       status_irq;
  logic       vblank_irq;
  logic       frame_done;
  logic       render_line;

  modport source (output valid, mode, line, coincidence, status_irq, vblank_irq,
                  frame_done, render_line, input ready);
  modport sink   (input valid, mode, line, coincidence, status_irq, vblank_irq,
                  frame_done, render_line, output ready);
endinterface

FILE: rtl/lmts_step.sv
module lmts_step (
  input  lmts_pkg::lmts_state_t  state_i,
  input  logic [5:0]             dots_i,
  input  logic                   lcd_enable_i,
  input  logic [7:0]             compare_line_i,
  input  logic [3:0]             irq_enables_i,
  output lmts_pkg::lmts_state_t  state_o,
  output lmts_pkg::lmts_result_t result_o
);
  import lmts_pkg::*;

  logic [10:0] sum;
  logic [9:0]  dots_sat;
  logic        line_match;
  mode_e       mode_nxt;
  logic        stat_req;
  logic        vbl_req;
  logic        frame;
  logic        render;

  // saturating dot accumulate
  assign sum      = {1'b0, state_i.dot_count} + {5'b0, dots_i};
  assign dots_sat = sum[10] ? DOT_MAX : sum[9:0];
  assign line_match = (state_i.cur_line == compare_line_i);

  // mode selection and interrupt requests
  always_comb begin
    mode_nxt = state_i.cur_mode;
    stat_req = line_match & irq_enables_i[IRQ_COINC];
    vbl_req  = 1'b0;
    frame    = 1'b0;
    render   = 1'b0;
    if (state_i.cur_line >= FIRST_VBLANK_LINE) begin
      if (state_i.cur_mode != MODE_VBLANK) begin
        mode_nxt = MODE_VBLANK;
        stat_req = irq_enables_i[IRQ_VBL_ENTRY];
        vbl_req  = 1'b1;
        frame    = 1'b1;
      end
    end else if (dots_sat <= OAM_END_DOT) begin
      if (state_i.cur_mode != MODE_OAM) begin
        mode_nxt = MODE_OAM;
        stat_req = irq_enables_i[IRQ_OAM];
      end
    end else if (dots_sat <= DRAW_END_DOT) begin
      mode_nxt = MODE_DRAW;
    end else if (dots_sat <= DOTS_PER_LINE) begin
      if (state_i.cur_mode != MODE_HBLANK) begin
        mode_nxt = MODE_HBLANK;
        stat_req = irq_enables_i[IRQ_HBLANK];
        render   = 1'b1;
      end
    end
  end

  // next state, with end-of-line wrap and display-off clear
  always_comb begin
    state_o = state_i;
    if (!lcd_enable_i) begin
      state_o.dot_count = '0;
      state_o.cur_line  = '0;
      state_o.cur_mode  = MODE_HBLANK;
    end else begin
      state_o.coinc_flag = line_match;
      state_o.cur_mode   = mode_nxt;
      state_o.dot_count  = dots_sat;
      if (dots_sat >= DOTS_PER_LINE) begin
        state_o.dot_count = dots_sat - DOTS_PER_LINE;
        state_o.cur_line  = (state_i.cur_line >= LAST_LINE) ? 8'd0 : state_i.cur_line + 8'd1;
      end
    end
  end

  // result beat
  always_comb begin
    result_o.mode        = state_o.cur_mode;
    result_o.line        = state_o.cur_line;
    result_o.coincidence = state_o.coinc_flag;
    result_o.status_irq  = lcd_enable_i & stat_req;
    result_o.vblank_irq  = lcd_enable_i & vbl_req;
    result_o.frame_done  = lcd_enable_i & frame;
    result_o.render_line = lcd_enable_i & render;
  end

endmodule

FILE: rtl/lcd_mode_timing_sequencer.sv
// Result: registered; an accepted input beat's result beat appears in the cycle after it is accepted.
// Throughput: one beat per cycle; the single result register takes a new
// beat whenever it is empty or being drained in the same cycle.
// Reset: asynchronous, active low; clears the dot counter, line, mode,
// coincidence flag and the result valid.
module lcd_mode_timing_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  lmts_in_if.sink         in_i,
  lmts_out_if.source      res_o
);
  import lmts_pkg::*;

  lmts_state_t  state_q;
  lmts_state_t  state_d;
  lmts_result_t result_q;
  lmts_result_t result_d;
  logic         valid_q;
  logic         accept;

  // handshake
  assign in_i.ready = !valid_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // per-beat update logic
  lmts_step u_step (
    .state_i        (state_q),
    .dots_i         (in_i.dots),
    .lcd_enable_i   (in_i.lcd_enable),
    .compare_line_i (in_i.compare_line),
    .irq_enables_i  (in_i.irq_enables),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // sequencer state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{dot_count: '0, cur_line: '0, cur_mode: MODE_HBLANK, coinc_flag: 1'b0};
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (in_i.ready) begin
        valid_q <= in_i.valid;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  // output drive
  assign res_o.valid       = valid_q;
  assign res_o.mode        = result_q.mode;
  assign res_o.line        = result_q.line;
  assign res_o.coincidence = result_q.coincidence;
  assign res_o.status_irq  = result_q.status_irq;
  assign res_o.vblank_irq  = result_q.vblank_irq;
  assign res_o.frame_done  = result_q.frame_done;
  assign res_o.render_line = result_q.render_line;

endmodule
